FILE: hdl/packed_rgba_overlay_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// Overlay blend unit assertion macros
// Shared assertion shorthands for the blend unit checker.
// ----------------------------------------------------------------------------
`ifndef PACKED_RGBA_OVERLAY_BLEND_UNIT_DEFINES_SVH
`define PACKED_RGBA_OVERLAY_BLEND_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define POBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define POBL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pobl_pkg.sv
// ----------------------------------------------------------------------------
// Overlay blend package
// Shared types, register indexes and arithmetic helpers.
// ----------------------------------------------------------------------------
package pobl_pkg;

    localparam int REM_W = 24;
    localparam int DEN_W = 16;
    localparam int Q_W   = 8;

    localparam logic [7:0] REG_MAIN_ALPHA = 8'd0;
    localparam logic [7:0] REG_STRAIGHT   = 8'd1;

    // Item travelling down the divider cell row
    typedef struct packed {
        logic [7:0]       main_blue;
        logic [7:0]       main_green;
        logic [7:0]       main_red;
        logic [7:0]       main_opacity;
        logic [7:0]       over_blue;
        logic [7:0]       over_green;
        logic [7:0]       over_red;
        logic [7:0]       over_opacity;
        logic             div_en;
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
    } pobl_div_t;

    // Products stage of the mixer
    typedef struct packed {
        logic [7:0]  main_blue;
        logic [7:0]  main_green;
        logic [7:0]  main_red;
        logic [7:0]  main_opacity;
        logic [7:0]  over_blue;
        logic [7:0]  over_green;
        logic [7:0]  over_red;
        logic [7:0]  over_opacity;
        logic        a_zero;
        logic        a_full;
        logic [15:0] blue_mix;
        logic [15:0] green_mix;
        logic [15:0] red_mix;
        logic [15:0] blue_keep;
        logic [15:0] green_keep;
        logic [15:0] red_keep;
        logic [15:0] alpha_prod;
    } pobl_mix_t;

    // Rounded divide by 255: ((x + 128) * 257) >> 16
    function automatic logic [7:0] div255r(input logic [15:0] x);
        logic [16:0] y;
        logic [24:0] p;
        y = 17'(x) + 17'd128;
        p = 25'(y) + (25'(y) << 8);
        return p[23:16];
    endfunction

endpackage

FILE: hdl/pobl_prep.sv
// ----------------------------------------------------------------------------
// Overlay blend input stage
// Registers the pixel pair and forms dividend and divisor of the alpha
// un-premultiply.
// ----------------------------------------------------------------------------
module pobl_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              main_alpha_present,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pobl_pkg::pobl_div_t out_item
);
    import pobl_pkg::*;

    logic      valid_reg;
    pobl_div_t item_reg;
    pobl_div_t item_next;
    logic [7:0] oa;
    logic [7:0] ma;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign oa = in_data[63:56];
    assign ma = in_data[31:24];

    always_comb
    begin
        item_next.main_blue    = in_data[7:0];
        item_next.main_green   = in_data[15:8];
        item_next.main_red     = in_data[23:16];
        item_next.main_opacity = ma;
        item_next.over_blue    = in_data[39:32];
        item_next.over_green   = in_data[47:40];
        item_next.over_red     = in_data[55:48];
        item_next.over_opacity = oa;
        item_next.div_en       = main_alpha_present && (oa != 8'd0) && (oa != 8'd255);
        item_next.rem          = REM_W'(oa) * REM_W'(65025);
        // 255*(a+m) - a*m rewritten as 255*a + m*(255-a), never above 65025
        item_next.den          = (DEN_W'(oa) << 8) - DEN_W'(oa)
                               + DEN_W'(ma) * DEN_W'(8'd255 - oa);
        item_next.quo          = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/pobl_div_cell.sv
// ----------------------------------------------------------------------------
// Overlay blend divider cell
// One restoring-division step: settles one quotient bit and hands the item on.
// ----------------------------------------------------------------------------
module pobl_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pobl_pkg::pobl_div_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pobl_pkg::pobl_div_t out_item
);
    import pobl_pkg::*;

    logic             valid_reg;
    pobl_div_t        item_reg;
    pobl_div_t        item_next;
    logic [REM_W-1:0] den_sh;
    logic             fits;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign den_sh = REM_W'(in_item.den) << SHIFT;
    assign fits   = in_item.rem >= den_sh;

    always_comb
    begin
        item_next = in_item;
        if (in_item.div_en)
        begin
            item_next.quo = {in_item.quo[Q_W-2:0], fits};
            if (fits)
            begin
                item_next.rem = in_item.rem - den_sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/pobl_mix.sv
// ----------------------------------------------------------------------------
// Overlay blend mixer
// Two stages: channel products, then rounding, selection and the output
// register.
// ----------------------------------------------------------------------------
module pobl_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                main_alpha_present,
    input  logic                straight_mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  pobl_pkg::pobl_div_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data
);
    import pobl_pkg::*;

    logic       prod_valid_reg;
    pobl_mix_t  prod_reg;
    pobl_mix_t  prod_next;
    logic       prod_ready;
    logic [7:0] a;
    logic [7:0] na;

    logic        out_valid_reg;
    logic [31:0] data_reg;
    logic [31:0] data_next;

    // Effective alpha: quotient when un-premultiplied, else raw overlay alpha
    assign a  = in_item.div_en ? in_item.quo : in_item.over_opacity;
    assign na = 8'd255 - a;

    assign out_valid  = out_valid_reg;
    assign out_data   = data_reg;
    assign prod_ready = !out_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    always_comb
    begin
        prod_next.main_blue    = in_item.main_blue;
        prod_next.main_green   = in_item.main_green;
        prod_next.main_red     = in_item.main_red;
        prod_next.main_opacity = in_item.main_opacity;
        prod_next.over_blue    = in_item.over_blue;
        prod_next.over_green   = in_item.over_green;
        prod_next.over_red     = in_item.over_red;
        prod_next.over_opacity = in_item.over_opacity;
        prod_next.a_zero       = (a == 8'd0);
        prod_next.a_full       = (a == 8'd255);
        prod_next.blue_keep    = 16'(in_item.main_blue) * 16'(na);
        prod_next.green_keep   = 16'(in_item.main_green) * 16'(na);
        prod_next.red_keep     = 16'(in_item.main_red) * 16'(na);
        prod_next.blue_mix     = prod_next.blue_keep + 16'(in_item.over_blue) * 16'(a);
        prod_next.green_mix    = prod_next.green_keep + 16'(in_item.over_green) * 16'(a);
        prod_next.red_mix      = prod_next.red_keep + 16'(in_item.over_red) * 16'(a);
        prod_next.alpha_prod   = 16'(8'd255 - in_item.main_opacity)
                               * 16'(in_item.over_opacity);
    end

    function automatic logic [7:0] pick(
        input logic       a_zero,
        input logic       a_full,
        input logic       straight,
        input logic [7:0] m,
        input logic [7:0] o,
        input logic [15:0] mix,
        input logic [15:0] keep
    );
        logic [8:0] sum;
        sum = 9'(div255r(keep)) + 9'(o);
        priority if (a_zero)
            return m;
        else if (a_full)
            return o;
        else if (straight)
            return div255r(mix);
        else
            return sum[8] ? 8'd255 : sum[7:0];
    endfunction

    always_comb
    begin
        data_next[7:0]   = pick(prod_reg.a_zero, prod_reg.a_full, straight_mode,
                                prod_reg.main_blue, prod_reg.over_blue,
                                prod_reg.blue_mix, prod_reg.blue_keep);
        data_next[15:8]  = pick(prod_reg.a_zero, prod_reg.a_full, straight_mode,
                                prod_reg.main_green, prod_reg.over_green,
                                prod_reg.green_mix, prod_reg.green_keep);
        data_next[23:16] = pick(prod_reg.a_zero, prod_reg.a_full, straight_mode,
                                prod_reg.main_red, prod_reg.over_red,
                                prod_reg.red_mix, prod_reg.red_keep);
        priority if (!main_alpha_present || prod_reg.a_zero)
            data_next[31:24] = prod_reg.main_opacity;
        else if (prod_reg.a_full)
            data_next[31:24] = prod_reg.over_opacity;
        else
            data_next[31:24] = prod_reg.main_opacity + div255r(prod_reg.alpha_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg && prod_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/packed_rgba_overlay_blend_unit.sv
// ----------------------------------------------------------------------------
// Packed RGBA overlay blend unit
// Blends overlay onto main BGRA pixels, one pair per clock when unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_t* carries a main/overlay pixel pair, m_t* the blended main pixel.
//   cfg_* writes the two mode registers (index 0: main alpha present,
//   index 1: straight mode); cfg_ready is always high, write only when idle.
// Pipeline: an input transfer reaches m_tvalid through one input stage,
//   eight divider cells (one quotient bit each) for the alpha
//   un-premultiply, one product stage and the output register.
// Throughput: one pixel per cycle; every stage holds its own valid bit, so
//   the row of cells keeps taking pixels into empty slots while a result
//   waits on m_tready, and stalls only once it is full.
// Reset: pipeline emptied, main alpha present = 0, straight mode = 1.
// Stall: m_tdata holds while m_tvalid && !m_tready; back pressure ripples
//   through the stage ready chain to s_tready.
// ----------------------------------------------------------------------------
module packed_rgba_overlay_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // main_blue, main_green, main_red, main_opacity,
    // over_blue, over_green, over_red, over_opacity
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_blue, out_green, out_red, out_opacity
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pobl_pkg::*;

    localparam int NCELL = Q_W;

    logic main_alpha_present_reg;
    logic straight_mode_reg;

    logic      cell_valid [NCELL+1];
    logic      cell_ready [NCELL+1];
    pobl_div_t cell_item  [NCELL+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_alpha_present_reg <= 1'b0;
            straight_mode_reg      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MAIN_ALPHA)
            begin
                main_alpha_present_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_STRAIGHT)
            begin
                straight_mode_reg <= cfg_data[0];
            end
        end
    end

    pobl_prep u_prep (
        .clk                (clk),
        .rst_n              (rst_n),
        .main_alpha_present (main_alpha_present_reg),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .in_data            (s_tdata),
        .out_valid          (cell_valid[0]),
        .out_ready          (cell_ready[0]),
        .out_item           (cell_item[0])
    );

    // Quotient bits from the top down: cell i weighs the divisor by 2^(7-i)
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        pobl_div_cell #(
            .SHIFT (NCELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_item   (cell_item[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_item  (cell_item[i+1])
        );
    end

    pobl_mix u_mix (
        .clk                (clk),
        .rst_n              (rst_n),
        .main_alpha_present (main_alpha_present_reg),
        .straight_mode      (straight_mode_reg),
        .in_valid           (cell_valid[NCELL]),
        .in_ready           (cell_ready[NCELL]),
        .in_item            (cell_item[NCELL]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_data           (m_tdata)
    );

endmodule

FILE: hdl/pobl_checker.sv
// ----------------------------------------------------------------------------
// Overlay blend port checker
// Port-level checks of the blend unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "packed_rgba_overlay_blend_unit_defines.svh"

module pobl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // Stalled result must hold
    `POBL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

    // Any free output slot means the whole row can move, so the input is open
    `POBL_ASSERT(a_in_open, !m_tvalid || m_tready |-> s_tready, "input closed while pipeline can drain")

    // Register writes are never refused
    `POBL_ASSERT(a_cfg_open, cfg_valid |-> cfg_ready, "config write refused")

    // Reset empties the output stage
    `POBL_ASSERT_RST(a_rst_empty, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind packed_rgba_overlay_blend_unit pobl_checker u_pobl_checker (.*);

FILE: dv/packed_rgba_overlay_blend_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Overlay blend unit testbench
// Streams main/overlay pixel pairs through the blend unit under every mode
// setting and several idle/stall patterns. A scoreboard predicts each
// blended pixel on input transfer and checks results in order.
// ----------------------------------------------------------------------------
module packed_rgba_overlay_blend_unit_tb;
    import pobl_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          ITEMS_PER_SET  = 92;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          SETTLE_CYCLES  = 24;
    localparam logic [7:0]  REG_UNMAPPED   = 8'd2;

    // last field in the lowest bits
    typedef struct packed {
        logic [7:0] over_opacity;
        logic [7:0] over_red;
        logic [7:0] over_green;
        logic [7:0] over_blue;
        logic [7:0] main_opacity;
        logic [7:0] main_red;
        logic [7:0] main_green;
        logic [7:0] main_blue;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] out_opacity;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } blended_px_t;

    class blend_scoreboard;
        bit            alpha_on;
        bit            straight_on;
        blended_px_t   blended_q[$];
        int            errors;

        function new();
            alpha_on      = 1'b0;
            straight_on   = 1'b1;
            errors        = 0;
        endfunction

        function void write_mode(logic [7:0] index, logic [7:0] value);
            if (index == REG_MAIN_ALPHA)
                alpha_on = value[0];
            else if (index == REG_STRAIGHT)
                straight_on = value[0];
        endfunction

        function int pending();
            return blended_q.size();
        endfunction

        function logic [7:0] div255_round(int unsigned x);
            int unsigned y;
            y = ((x + 128) * 257) >> 16;
            return 8'(y);
        endfunction

        function logic [7:0] mix_channel(logic [7:0] m, logic [7:0] o, int unsigned a);
            int unsigned sum;
            if (a == 0)
                return m;
            if (a == 255)
                return o;
            if (straight_on)
                return div255_round(m * (255 - a) + o * a);
            sum = div255_round(m * (255 - a)) + o;
            return (sum > 255) ? 8'hFF : 8'(sum);
        endfunction

        function void note_pixel_pair(pixel_pair_t px);
            int unsigned alpha;
            int unsigned ma;
            int unsigned numer;
            int unsigned denom;
            blended_px_t blended;
            alpha = px.over_opacity;
            ma    = px.main_opacity;
            // overlay alpha un-premultiplied against main alpha
            if (alpha_on && alpha != 0 && alpha != 255) begin
                numer = 65025 * alpha;
                denom = 255 * (alpha + ma) - alpha * ma;
                alpha = (numer / denom) & 32'hFF;
            end
            blended.out_blue  = mix_channel(px.main_blue, px.over_blue, alpha);
            blended.out_green = mix_channel(px.main_green, px.over_green, alpha);
            blended.out_red   = mix_channel(px.main_red, px.over_red, alpha);
            blended.out_opacity = px.main_opacity;
            if (alpha_on) begin
                if (alpha == 255)
                    blended.out_opacity = px.over_opacity;
                else if (alpha != 0)
                    blended.out_opacity = 8'(ma + div255_round((255 - ma) * px.over_opacity));
            end
            blended_q.push_back(blended);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_blended(blended_px_t got);
            blended_px_t want;
            if (blended_q.size() == 0) begin
                $error("result transfer with no pixel pending: %h", got);
                errors++;
                return;
            end
            want = blended_q.pop_front();
            compare_field("out_blue", want.out_blue, got.out_blue);
            compare_field("out_green", want.out_green, got.out_green);
            compare_field("out_red", want.out_red, got.out_red);
            compare_field("out_opacity", want.out_opacity, got.out_opacity);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    blend_scoreboard sb;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;

    packed_rgba_overlay_blend_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check transfers, random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_blended(blended_px_t'(m_tdata));
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pair(input pixel_pair_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel_pair(px);
    endtask

    // Sender stops and waits for every blended pixel to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_mode(index, value);
    endtask

    // Upper data bits are junk on purpose; only bit 0 should stick
    task automatic set_modes(input bit alpha_en, input bit straight);
        write_reg(REG_MAIN_ALPHA, {7'($urandom), alpha_en});
        write_reg(REG_UNMAPPED, 8'($urandom));
        write_reg(REG_STRAIGHT, {7'($urandom), straight});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic pixel_pair_t make_pair(logic [7:0] mb, logic [7:0] mg, logic [7:0] mr,
                                              logic [7:0] ma, logic [7:0] ob, logic [7:0] og,
                                              logic [7:0] ovr, logic [7:0] oa);
        pixel_pair_t px;
        px.main_blue    = mb;
        px.main_green   = mg;
        px.main_red     = mr;
        px.main_opacity = ma;
        px.over_blue    = ob;
        px.over_green   = og;
        px.over_red     = ovr;
        px.over_opacity = oa;
        return px;
    endfunction

    // Opacities lean toward the edges where the special cases live
    function automatic pixel_pair_t random_pair();
        pixel_pair_t px;
        px = pixel_pair_t'({$urandom, $urandom});
        case ($urandom_range(9))
            0: px.over_opacity = 8'd0;
            1: px.over_opacity = 8'd255;
            2: px.over_opacity = 8'($urandom_range(1, 3));
            3: px.over_opacity = 8'($urandom_range(252, 254));
            default: ;
        endcase
        case ($urandom_range(7))
            0: px.main_opacity = 8'd0;
            1: px.main_opacity = 8'd255;
            default: ;
        endcase
        return px;
    endfunction

    pixel_pair_t directed_px[8];
    int          send_idle_tab[4] = '{0, 70, 0, 29};
    int          recv_stall_tab[4] = '{0, 0, 70, 29};
    bit          alpha_tab[4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    bit          straight_tab[4] = '{1'b1, 1'b1, 1'b0, 1'b0};

    initial
    begin
        sb = new();
        directed_px[0] = make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        directed_px[1] = make_pair(8'd255, 8'd255, 8'd255, 8'd255,
                                   8'd255, 8'd255, 8'd255, 8'd255);
        // transparent overlay keeps main colour
        directed_px[2] = make_pair(8'd12, 8'd200, 8'd77, 8'd90, 8'd250, 8'd3, 8'd140, 8'd0);
        // opaque overlay copies its colour
        directed_px[3] = make_pair(8'd12, 8'd200, 8'd77, 8'd90, 8'd250, 8'd3, 8'd140, 8'd255);
        // fully transparent main lifts the overlay alpha to opaque
        directed_px[4] = make_pair(8'd30, 8'd60, 8'd90, 8'd0, 8'd200, 8'd150, 8'd100, 8'd128);
        // faintest overlay on opaque main
        directed_px[5] = make_pair(8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1);
        // premultiplied add saturates
        directed_px[6] = make_pair(8'd255, 8'd250, 8'd240, 8'd255,
                                   8'd255, 8'd200, 8'd230, 8'd254);
        directed_px[7] = make_pair(8'd0, 8'd255, 8'd85, 8'd100, 8'd255, 8'd0, 8'd170, 8'd200);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset modes first, then two written settings
        for (int c = 0; c < 3; c++)
        begin
            if (c == 1)
                set_modes(1'b1, 1'b0);
            else if (c == 2)
                set_modes(1'b1, 1'b1);
            foreach (directed_px[i])
                send_pair(directed_px[i]);
            drain();
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_idle_tab[ph];
            recv_stall_pct = recv_stall_tab[ph];
            for (int c = 0; c < 4; c++)
            begin
                set_modes(alpha_tab[(c + ph) % 4], straight_tab[(c + ph) % 4]);
                for (int n = 0; n < ITEMS_PER_SET; n++)
                begin
                    if (n == ITEMS_PER_SET / 2 && c == ph)
                        drain();
                    send_pair(random_pair());
                end
                drain();
            end
        end

        // Back pressure: receiver holds off while the sender keeps pushing
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_modes(1'b1, 1'b0);
        hold_req <= ~hold_req;
        for (int n = 0; n < 40; n++)
            send_pair(random_pair());
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
